FILE: rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants, types and helpers of the first-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

    // sizing
    localparam int THREADS    = 4;
    localparam int ENTRIES    = 16;
    localparam int WORD_BYTES = 8;
    localparam int HEAP_LIMIT = 65536;

    // field widths
    localparam int TID_W  = 2;
    localparam int OFF_W  = 16;
    localparam int SIZE_W = 17;
    localparam int NEED_W = SIZE_W + 1;

    // table indexing
    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int THR_W  = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int SLOTS  = THREADS * ENTRIES;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int NEXT_W = IDX_W + 1;

    localparam logic [NEXT_W-1:0] LIST_END = '1;

    // reciprocal used to divide by the word size
    localparam int RECIP_SHIFT = SIZE_W;
    localparam int RECIP       = (1 << RECIP_SHIFT) / WORD_BYTES;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SIZE_W + RECIP_W;

    // effective heap after reset
    localparam int HEAP_ROUND = (HEAP_LIMIT + WORD_BYTES - 1) / WORD_BYTES * WORD_BYTES;
    localparam int HEAP_RESET = (HEAP_ROUND > HEAP_LIMIT) ? HEAP_ROUND - WORD_BYTES
                                                          : HEAP_ROUND;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_ZERO_SIZE = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_WALK,
        S_SPLIT,
        S_DONE
    } walk_state_t;

    // one block table entry
    typedef struct packed {
        logic [OFF_W-1:0]  offset;
        logic [SIZE_W-1:0] size;
        logic              in_use;
        logic [NEXT_W-1:0] next;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // walker to table
    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [THR_W-1:0] tid;
        logic [IDX_W-1:0] rd_idx;
        logic [IDX_W-1:0] wr_idx;
        entry_t           wr_data;
    } tbl_req_t;

    // table to walker
    typedef struct packed {
        entry_t           rd_data;
        logic [IDX_W-1:0] spare_idx;
        logic             spare_ok;
        logic             busy;
    } tbl_rsp_t;

    // finished result
    typedef struct packed {
        logic             valid;
        logic [OFF_W-1:0] offset;
        status_t          status;
    } res_t;

    // round up to whole words, given prod = v * RECIP
    function automatic logic [NEED_W-1:0] round_up(
        input logic [SIZE_W-1:0] v,
        input logic [PROD_W-1:0] prod
    );
        logic [NEED_W-1:0] q0;
        logic [NEED_W-1:0] r0;
        logic [NEED_W-1:0] r;
        logic [NEED_W-1:0] pad;
        q0  = NEED_W'(prod >> RECIP_SHIFT);
        r0  = {1'b0, v} - NEED_W'(q0 * NEED_W'(WORD_BYTES));
        r   = (r0 >= NEED_W'(WORD_BYTES)) ? r0 - NEED_W'(WORD_BYTES) : r0;
        pad = (r != '0) ? NEED_W'(WORD_BYTES) - r : '0;
        return {1'b0, v} + pad;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/first_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit heap block allocator with block split, one table per thread.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request walks its thread's list,
// one RAM read per entry visited (1 to 16 entries), and an allocate that
// splits a block adds a write step for the upper part; zero-size requests
// and bad thread ids skip the walk. The next request is taken in the idle
// state, which follows once the result moves to the output register, so
// requests do not overlap. The list walk through the single entry RAM sets
// the request rate. Results sit in an output register, so the next request
// is taken while a result waits. Tables need no clearing pass: per entry
// valid bits make unwritten entries read as their reset value. After a heap
// size write the request side stalls until the new heap size is registered.
`default_nettype none

module first_fit_block_allocator_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        cfg_wr_en,
    input  wire logic [ffba_pkg::SIZE_W-1:0] cfg_wr_data,

    input  wire logic                        req_valid,
    output logic                             req_stall,
    input  wire logic                        operation,
    input  wire logic [ffba_pkg::TID_W-1:0]  thread_id,
    input  wire logic [ffba_pkg::SIZE_W-1:0] request_bytes,
    input  wire logic [ffba_pkg::OFF_W-1:0]  free_offset,

    output logic                             rsp_valid,
    input  wire logic                        rsp_stall,
    output logic      [ffba_pkg::OFF_W-1:0]  granted_offset,
    output logic      [1:0]                  status
);

    ffba_pkg::tbl_req_t tbl_req;
    ffba_pkg::tbl_rsp_t tbl_rsp;
    ffba_pkg::res_t     res;
    logic               res_take;

    logic                       rsp_valid_reg;
    logic [ffba_pkg::OFF_W-1:0] granted_offset_reg;
    ffba_pkg::status_t          status_reg;

    // block tables
    ffba_table u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .tbl_req     (tbl_req),
        .tbl_rsp     (tbl_rsp)
    );

    // request sequencer
    ffba_walker u_walker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .operation     (operation),
        .thread_id     (thread_id),
        .request_bytes (request_bytes),
        .free_offset   (free_offset),
        .tbl_req       (tbl_req),
        .tbl_rsp       (tbl_rsp),
        .res           (res),
        .res_take      (res_take)
    );

    // output register takes a result when empty or being drained
    assign res_take = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res.valid && res_take)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && res_take)
        begin
            granted_offset_reg <= res.offset;
            status_reg         <= res.status;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign granted_offset = granted_offset_reg;
    assign status         = status_reg;

endmodule

`default_nettype wire

FILE: rtl/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ffba_table.sv
// ----------------------------------------------------------------------------
// ffba_table
// Block tables of all threads: entry RAM, per-entry valid and occupied bits,
// heap size register and spare entry search.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_table (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [ffba_pkg::SIZE_W-1:0]  cfg_wr_data,
    input  wire ffba_pkg::tbl_req_t           tbl_req,
    output ffba_pkg::tbl_rsp_t                tbl_rsp
);

    // heap size handling
    logic [ffba_pkg::SIZE_W-1:0] heap_clamp;
    logic [ffba_pkg::SIZE_W-1:0] heap_clamp_reg;
    logic [ffba_pkg::PROD_W-1:0] heap_prod_reg;
    logic [ffba_pkg::NEED_W-1:0] heap_round;
    logic [ffba_pkg::SIZE_W-1:0] heap_eff_next;
    logic [ffba_pkg::SIZE_W-1:0] heap_eff_reg;
    logic                        cfg_pend_reg;

    // table state kept in flops
    logic [ffba_pkg::ENTRIES-1:0] valid_reg [ffba_pkg::THREADS];
    logic [ffba_pkg::ENTRIES-1:0] occ_reg   [ffba_pkg::THREADS];
    logic [ffba_pkg::ENTRIES-1:0] occ_eff;

    // ram access
    logic [ffba_pkg::SLOT_W-1:0]  rd_slot;
    logic [ffba_pkg::SLOT_W-1:0]  wr_slot;
    logic [ffba_pkg::ENTRY_W-1:0] ram_q;
    logic                         rd_valid_reg;
    logic                         rd_head_reg;
    ffba_pkg::entry_t             rst_entry;

    function automatic logic [ffba_pkg::SLOT_W-1:0] slot_of(
        input logic [ffba_pkg::THR_W-1:0] t,
        input logic [ffba_pkg::IDX_W-1:0] i
    );
        return ffba_pkg::SLOT_W'(ffba_pkg::SLOT_W'(t) * ffba_pkg::SLOT_W'(ffba_pkg::ENTRIES))
             + ffba_pkg::SLOT_W'(i);
    endfunction

    // clamp and scale the written heap size
    assign heap_clamp = (cfg_wr_data > ffba_pkg::SIZE_W'(ffba_pkg::HEAP_LIMIT))
                      ? ffba_pkg::SIZE_W'(ffba_pkg::HEAP_LIMIT) : cfg_wr_data;

    always_ff @(posedge clk)
    begin
        if (cfg_wr_en)
        begin
            heap_clamp_reg <= heap_clamp;
            heap_prod_reg  <= ffba_pkg::PROD_W'(heap_clamp)
                            * ffba_pkg::PROD_W'(ffba_pkg::RECIP);
        end
    end

    // word rounding of the heap, one word off if it passes the limit
    always_comb
    begin
        heap_round = ffba_pkg::round_up(heap_clamp_reg, heap_prod_reg);
        if (heap_round > ffba_pkg::NEED_W'(ffba_pkg::HEAP_LIMIT))
        begin
            heap_eff_next = ffba_pkg::SIZE_W'(heap_round
                          - ffba_pkg::NEED_W'(ffba_pkg::WORD_BYTES));
        end
        else
        begin
            heap_eff_next = ffba_pkg::SIZE_W'(heap_round);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_eff_reg <= ffba_pkg::SIZE_W'(ffba_pkg::HEAP_RESET);
            cfg_pend_reg <= 1'b0;
        end
        else
        begin
            cfg_pend_reg <= cfg_wr_en;
            if (cfg_pend_reg)
            begin
                heap_eff_reg <= heap_eff_next;
            end
        end
    end

    // valid bits: cleared by reset and by a heap size write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < ffba_pkg::THREADS; t++)
            begin
                valid_reg[t] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            for (int t = 0; t < ffba_pkg::THREADS; t++)
            begin
                valid_reg[t] <= '0;
            end
        end
        else if (tbl_req.wr_en)
        begin
            valid_reg[tbl_req.tid][tbl_req.wr_idx] <= 1'b1;
        end
    end

    // occupied bits: entry holds a nonzero size
    always_ff @(posedge clk)
    begin
        if (tbl_req.wr_en)
        begin
            occ_reg[tbl_req.tid][tbl_req.wr_idx] <= (tbl_req.wr_data.size != '0);
        end
    end

    // first spare entry of the selected thread, read data and busy flag
    always_comb
    begin
        tbl_rsp.spare_ok  = 1'b0;
        tbl_rsp.spare_idx = '0;
        for (int k = 0; k < ffba_pkg::ENTRIES; k++)
        begin
            if (valid_reg[tbl_req.tid][k])
            begin
                occ_eff[k] = occ_reg[tbl_req.tid][k];
            end
            else
            begin
                occ_eff[k] = (k == 0) && (heap_eff_reg != '0);
            end
        end
        for (int k = ffba_pkg::ENTRIES - 1; k >= 0; k--)
        begin
            if (!occ_eff[k])
            begin
                tbl_rsp.spare_ok  = 1'b1;
                tbl_rsp.spare_idx = ffba_pkg::IDX_W'(k);
            end
        end
        tbl_rsp.rd_data = rd_valid_reg ? ffba_pkg::entry_t'(ram_q) : rst_entry;
        tbl_rsp.busy    = cfg_pend_reg;
    end

    // entry ram
    assign rd_slot = slot_of(tbl_req.tid, tbl_req.rd_idx);
    assign wr_slot = slot_of(tbl_req.tid, tbl_req.wr_idx);

    ffba_ram #(
        .WIDTH (ffba_pkg::ENTRY_W),
        .DEPTH (ffba_pkg::SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (tbl_req.wr_en),
        .wr_addr (wr_slot),
        .wr_data (tbl_req.wr_data),
        .rd_en   (tbl_req.rd_en),
        .rd_addr (rd_slot),
        .rd_data (ram_q)
    );

    // remember whether the read entry was ever written
    always_ff @(posedge clk)
    begin
        if (tbl_req.rd_en)
        begin
            rd_valid_reg <= valid_reg[tbl_req.tid][tbl_req.rd_idx];
            rd_head_reg  <= (tbl_req.rd_idx == '0);
        end
    end

    // unwritten entries read as their reset value
    always_comb
    begin
        rst_entry.offset = '0;
        rst_entry.size   = rd_head_reg ? heap_eff_reg : '0;
        rst_entry.in_use = 1'b0;
        rst_entry.next   = ffba_pkg::LIST_END;
    end

    // no table write while the heap size is still settling
    a_no_wr_pending: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_pend_reg |-> !tbl_req.wr_en)
        else $error("table written while heap size update pending");

endmodule

`default_nettype wire

FILE: rtl/ffba_walker.sv
// ----------------------------------------------------------------------------
// ffba_walker
// Per-request sequencer: rounds the size, walks the thread's list one entry
// read per cycle, and writes back the allocate, split or free.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_walker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_stall,
    input  wire logic                        operation,
    input  wire logic [ffba_pkg::TID_W-1:0]  thread_id,
    input  wire logic [ffba_pkg::SIZE_W-1:0] request_bytes,
    input  wire logic [ffba_pkg::OFF_W-1:0]  free_offset,
    output ffba_pkg::tbl_req_t               tbl_req,
    input  wire ffba_pkg::tbl_rsp_t          tbl_rsp,
    output ffba_pkg::res_t                   res,
    input  wire logic                        res_take
);

    ffba_pkg::walk_state_t state_reg, state_next;

    // item registers
    logic                        op_reg;
    logic [ffba_pkg::TID_W-1:0]  tid_reg;
    logic [ffba_pkg::SIZE_W-1:0] req_bytes_reg;
    logic [ffba_pkg::PROD_W-1:0] prod_reg;
    logic [ffba_pkg::OFF_W-1:0]  free_off_reg;
    logic [ffba_pkg::NEED_W-1:0] need_reg, need_next;

    // walk registers
    logic [ffba_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [ffba_pkg::IDX_W-1:0]  step_reg, step_next;
    logic [ffba_pkg::IDX_W-1:0]  spare_reg, spare_next;
    logic [ffba_pkg::OFF_W-1:0]  hold_off_reg, hold_off_next;
    logic [ffba_pkg::SIZE_W-1:0] hold_size_reg, hold_size_next;
    logic [ffba_pkg::NEXT_W-1:0] hold_next_reg, hold_next_next;

    // result registers
    logic [ffba_pkg::OFF_W-1:0]  res_off_reg, res_off_next;
    ffba_pkg::status_t           res_status_reg, res_status_next;

    // decode of the current item and entry
    logic                        accept;
    logic                        tid_bad;
    logic                        zero_req;
    logic [ffba_pkg::NEED_W-1:0] need_round;
    ffba_pkg::entry_t            ent;
    logic                        fits;
    logic                        split;
    logic                        hit;
    logic                        last;
    logic [ffba_pkg::OFF_W-1:0]  split_off;

    assign req_stall = (state_reg != ffba_pkg::S_IDLE) || tbl_rsp.busy;
    assign accept    = req_valid && !req_stall;

    assign tid_bad    = (32'(tid_reg) >= ffba_pkg::THREADS);
    assign zero_req   = (op_reg == ffba_pkg::OP_ALLOC) && (req_bytes_reg == '0);
    assign need_round = ffba_pkg::round_up(req_bytes_reg, prod_reg);

    // entry checks during the walk
    assign ent   = tbl_rsp.rd_data;
    assign fits  = !ent.in_use && ({1'b0, ent.size} >= need_reg);
    assign split = fits && ({1'b0, ent.size} > need_reg) && tbl_rsp.spare_ok;
    assign hit   = (op_reg == ffba_pkg::OP_ALLOC) ? fits : (ent.offset == free_off_reg);
    assign last  = (step_reg == ffba_pkg::IDX_W'(ffba_pkg::ENTRIES - 1))
                || (ent.next >= ffba_pkg::NEXT_W'(ffba_pkg::ENTRIES));

    assign split_off = hold_off_reg + ffba_pkg::OFF_W'(hold_size_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffba_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = ffba_pkg::S_ROUND;
                end
            end
            ffba_pkg::S_ROUND:
            begin
                state_next = (tid_bad || zero_req) ? ffba_pkg::S_DONE : ffba_pkg::S_WALK;
            end
            ffba_pkg::S_WALK:
            begin
                if ((op_reg == ffba_pkg::OP_ALLOC) && split)
                begin
                    state_next = ffba_pkg::S_SPLIT;
                end
                else if (hit || last)
                begin
                    state_next = ffba_pkg::S_DONE;
                end
            end
            ffba_pkg::S_SPLIT:
            begin
                state_next = ffba_pkg::S_DONE;
            end
            ffba_pkg::S_DONE:
            begin
                if (res_take)
                begin
                    state_next = ffba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffba_pkg::S_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        tbl_req.rd_en   = 1'b0;
        tbl_req.wr_en   = 1'b0;
        tbl_req.tid     = ffba_pkg::THR_W'(tid_reg);
        tbl_req.rd_idx  = '0;
        tbl_req.wr_idx  = idx_reg;
        tbl_req.wr_data = ent;

        need_next       = need_reg;
        idx_next        = idx_reg;
        step_next       = step_reg;
        spare_next      = spare_reg;
        hold_off_next   = hold_off_reg;
        hold_size_next  = hold_size_reg;
        hold_next_next  = hold_next_reg;
        res_off_next    = res_off_reg;
        res_status_next = res_status_reg;

        res.valid  = (state_reg == ffba_pkg::S_DONE);
        res.offset = res_off_reg;
        res.status = res_status_reg;

        case (state_reg)
            ffba_pkg::S_ROUND:
            begin
                need_next    = need_round;
                res_off_next = '0;
                if (tid_bad)
                begin
                    res_status_next = (op_reg == ffba_pkg::OP_FREE) ? ffba_pkg::ST_NOT_FOUND
                                                                   : ffba_pkg::ST_NO_FIT;
                end
                else if (zero_req)
                begin
                    res_status_next = ffba_pkg::ST_ZERO_SIZE;
                end
                else
                begin
                    // start at the list head
                    tbl_req.rd_en = 1'b1;
                    idx_next      = '0;
                    step_next     = '0;
                end
            end
            ffba_pkg::S_WALK:
            begin
                if ((op_reg == ffba_pkg::OP_ALLOC) && split)
                begin
                    // lower part stays free and links to the spare entry
                    tbl_req.wr_en          = 1'b1;
                    tbl_req.wr_data.size   = ent.size - ffba_pkg::SIZE_W'(need_reg);
                    tbl_req.wr_data.in_use = 1'b0;
                    tbl_req.wr_data.next   = ffba_pkg::NEXT_W'(tbl_rsp.spare_idx);
                    spare_next     = tbl_rsp.spare_idx;
                    hold_off_next  = ent.offset;
                    hold_size_next = ent.size - ffba_pkg::SIZE_W'(need_reg);
                    hold_next_next = ent.next;
                end
                else if (hit)
                begin
                    // whole block taken, or block released
                    tbl_req.wr_en          = 1'b1;
                    tbl_req.wr_data.in_use = (op_reg == ffba_pkg::OP_ALLOC);
                    res_off_next    = (op_reg == ffba_pkg::OP_ALLOC) ? ent.offset : '0;
                    res_status_next = ffba_pkg::ST_OK;
                end
                else if (last)
                begin
                    res_off_next    = '0;
                    res_status_next = (op_reg == ffba_pkg::OP_ALLOC) ? ffba_pkg::ST_NO_FIT
                                                                    : ffba_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    // follow the link
                    tbl_req.rd_en  = 1'b1;
                    tbl_req.rd_idx = ffba_pkg::IDX_W'(ent.next);
                    idx_next       = ffba_pkg::IDX_W'(ent.next);
                    step_next      = step_reg + 1'b1;
                end
            end
            ffba_pkg::S_SPLIT:
            begin
                // upper part goes to the spare entry, marked used
                tbl_req.wr_en          = 1'b1;
                tbl_req.wr_idx         = spare_reg;
                tbl_req.wr_data.offset = split_off;
                tbl_req.wr_data.size   = ffba_pkg::SIZE_W'(need_reg);
                tbl_req.wr_data.in_use = 1'b1;
                tbl_req.wr_data.next   = hold_next_reg;
                res_off_next           = split_off;
                res_status_next        = ffba_pkg::ST_OK;
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffba_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= operation;
            tid_reg       <= thread_id;
            req_bytes_reg <= request_bytes;
            prod_reg      <= ffba_pkg::PROD_W'(request_bytes)
                           * ffba_pkg::PROD_W'(ffba_pkg::RECIP);
            free_off_reg  <= free_offset;
        end
    end

    // walk and result payload
    always_ff @(posedge clk)
    begin
        need_reg       <= need_next;
        idx_reg        <= idx_next;
        step_reg       <= step_next;
        spare_reg      <= spare_next;
        hold_off_reg   <= hold_off_next;
        hold_size_reg  <= hold_size_next;
        hold_next_reg  <= hold_next_next;
        res_off_reg    <= res_off_next;
        res_status_reg <= res_status_next;
    end

    a_one_port_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(tbl_req.rd_en && tbl_req.wr_en))
        else $error("table read and write in the same cycle");

    a_accept_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ffba_pkg::S_ROUND))
        else $error("accepted beat did not start rounding");

    a_fail_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.status != ffba_pkg::ST_OK)) |-> (res.offset == '0))
        else $error("failed request carries an offset");

    a_split_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffba_pkg::S_SPLIT) |-> ($past(state_reg) == ffba_pkg::S_WALK))
        else $error("split entered without a walk hit");

endmodule

`default_nettype wire

FILE: tb/first_fit_block_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core_tb
// Self-checking bench for the per-thread first-fit heap allocator. A local
// copy of the block tables predicts every answer: first-fit walk, block
// split into a used upper part, whole-block grant once spare entries run
// out, exact-offset free without coalescing. Directed corner beats come
// first, then random allocate/free traffic over several heap sizes, with
// bursty request timing, patterned response stalls and one long hold-off.
// ----------------------------------------------------------------------------

module first_fit_block_allocator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NT          = ffba_pkg::THREADS;
    localparam int NE          = ffba_pkg::ENTRIES;
    localparam int WB          = ffba_pkg::WORD_BYTES;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic [ffba_pkg::OFF_W-1:0] offset;
        ffba_pkg::status_t          status;
    } grant_t;

    // clock, reset and block ports
    logic                          clk;
    logic                          rst_n         = 1'b0;
    logic                          cfg_wr_en     = 1'b0;
    logic [ffba_pkg::SIZE_W-1:0]   cfg_wr_data   = '0;
    logic                          req_valid     = 1'b0;
    logic                          req_stall;
    logic                          operation     = ffba_pkg::OP_ALLOC;
    logic [ffba_pkg::TID_W-1:0]    thread_id     = '0;
    logic [ffba_pkg::SIZE_W-1:0]   request_bytes = '0;
    logic [ffba_pkg::OFF_W-1:0]    free_offset   = '0;
    logic                          rsp_valid;
    logic                          rsp_stall     = 1'b0;
    logic [ffba_pkg::OFF_W-1:0]    granted_offset;
    logic [1:0]                    status;

    // shadow block tables
    logic [ffba_pkg::SIZE_W-1:0]   heap_reg;
    logic [ffba_pkg::OFF_W-1:0]    blk_off  [NT][NE];
    logic [ffba_pkg::SIZE_W-1:0]   blk_size [NT][NE];
    bit                            blk_used [NT][NE];
    int                            blk_next [NT][NE];

    grant_t              pending_answers[$];
    grant_t              arrived_want;

    // bookkeeping
    int                  fail_count     = 0;
    int                  beats_checked  = 0;
    int                  beats_sent     = 0;
    int                  heap_writes    = 0;
    int                  status_seen[4] = '{0, 0, 0, 0};
    int                  cycle_count    = 0;
    bit                  gaps_on        = 1'b1;
    int                  burst_left     = 0;
    bit                  long_hold_pending = 1'b0;
    int                  hold_left      = 0;
    int                  long_holds     = 0;
    int                  stall_mode     = 0;
    int                  window_left    = 0;

    first_fit_block_allocator_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .operation      (operation),
        .thread_id      (thread_id),
        .request_bytes  (request_bytes),
        .free_offset    (free_offset),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .granted_offset (granted_offset),
        .status         (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d answers outstanding",
                     cycle_count, pending_answers.size());
            $display("first_fit_block_allocator_core_tb: errors");
            $finish;
        end
    end

    function automatic int unsigned words_up(input int unsigned v);
        return (v + WB - 1) / WB * WB;
    endfunction

    function automatic int unsigned usable_heap();
        int unsigned h;
        h = (heap_reg > ffba_pkg::HEAP_LIMIT) ? ffba_pkg::HEAP_LIMIT : heap_reg;
        h = words_up(h);
        if (h > ffba_pkg::HEAP_LIMIT)
            h -= WB;
        return h;
    endfunction

    // every thread back to one free block spanning the heap
    function automatic void clear_heap_tables();
        for (int t = 0; t < NT; t++)
        begin
            for (int e = 0; e < NE; e++)
            begin
                blk_off[t][e]  = '0;
                blk_size[t][e] = '0;
                blk_used[t][e] = 1'b0;
                blk_next[t][e] = int'(ffba_pkg::LIST_END);
            end
            blk_size[t][0] = ffba_pkg::SIZE_W'(usable_heap());
        end
    endfunction

    // first-fit allocate with split, or exact-offset free
    function automatic grant_t heap_answer(input logic op,
                                           input logic [ffba_pkg::TID_W-1:0] tid,
                                           input logic [ffba_pkg::SIZE_W-1:0] req,
                                           input logic [ffba_pkg::OFF_W-1:0] off);
        grant_t      ans;
        int unsigned need;
        int          t;
        int          idx;
        int          steps;
        int          spare;
        int          i;
        ans.offset = '0;
        ans.status = ffba_pkg::ST_OK;
        t = tid;
        if (t >= NT)
        begin
            ans.status = (op == ffba_pkg::OP_FREE) ? ffba_pkg::ST_NOT_FOUND
                                                   : ffba_pkg::ST_NO_FIT;
            return ans;
        end
        idx = 0;
        if (op == ffba_pkg::OP_ALLOC)
        begin
            if (req == '0)
            begin
                ans.status = ffba_pkg::ST_ZERO_SIZE;
                return ans;
            end
            need = words_up(req);
            for (steps = 0; steps < NE && idx < NE; steps++)
            begin
                if (!blk_used[t][idx] && blk_size[t][idx] >= need)
                begin
                    spare = -1;
                    if (blk_size[t][idx] > need)
                        for (i = 0; i < NE; i++)
                            if (spare < 0 && blk_size[t][i] == '0)
                                spare = i;
                    // split: lower part stays free, upper part is granted
                    if (spare >= 0)
                    begin
                        blk_size[t][idx] = blk_size[t][idx] - ffba_pkg::SIZE_W'(need);
                        blk_off[t][spare]  = ffba_pkg::OFF_W'(blk_off[t][idx]
                                                            + blk_size[t][idx]);
                        blk_size[t][spare] = ffba_pkg::SIZE_W'(need);
                        blk_used[t][spare] = 1'b1;
                        blk_next[t][spare] = blk_next[t][idx];
                        blk_next[t][idx]   = spare;
                        ans.offset = blk_off[t][spare];
                        return ans;
                    end
                    blk_used[t][idx] = 1'b1;
                    ans.offset = blk_off[t][idx];
                    return ans;
                end
                idx = blk_next[t][idx];
            end
            ans.status = ffba_pkg::ST_NO_FIT;
        end
        else
        begin
            for (steps = 0; steps < NE && idx < NE; steps++)
            begin
                if (blk_off[t][idx] == off)
                begin
                    blk_used[t][idx] = 1'b0;
                    return ans;
                end
                idx = blk_next[t][idx];
            end
            ans.status = ffba_pkg::ST_NOT_FOUND;
        end
        return ans;
    endfunction

    // offset of a listed block, preferably one in use
    function automatic logic [ffba_pkg::OFF_W-1:0] pick_listed_offset(input int tid,
                                                                      input bit want_used);
        logic [ffba_pkg::OFF_W-1:0] used_offs[$];
        logic [ffba_pkg::OFF_W-1:0] all_offs[$];
        int                         idx;
        int                         steps;
        idx = 0;
        for (steps = 0; steps < NE && idx < NE; steps++)
        begin
            all_offs.push_back(blk_off[tid][idx]);
            if (blk_used[tid][idx])
                used_offs.push_back(blk_off[tid][idx]);
            idx = blk_next[tid][idx];
        end
        if (!want_used || used_offs.size() == 0)
            return all_offs[$urandom_range(0, all_offs.size() - 1)];
        return used_offs[$urandom_range(0, used_offs.size() - 1)];
    endfunction

    function automatic logic [ffba_pkg::SIZE_W-1:0] rand_request();
        int          r;
        int unsigned h;
        r = $urandom_range(0, 99);
        h = usable_heap();
        if (r < 2)
            return '0;
        else if (r < 62)
            return ffba_pkg::SIZE_W'($urandom_range(1, 64));
        else if (r < 87)
            return ffba_pkg::SIZE_W'($urandom_range(1, (h / 4 > 8) ? h / 4 : 8));
        else if (r < 95)
            return ffba_pkg::SIZE_W'($urandom_range(h / 2, h + 16));
        return ffba_pkg::SIZE_W'($urandom_range(0, 131071));
    endfunction

    // response side: random stall patterns plus an on-demand long hold-off
    always @(posedge clk)
    begin
        if (long_hold_pending)
        begin
            long_hold_pending = 1'b0;
            hold_left = LONG_HOLD;
            long_holds++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            if (window_left == 0)
            begin
                stall_mode  = $urandom_range(0, 3);
                window_left = $urandom_range(16, 96);
            end
            window_left--;
            case (stall_mode)
                0: rsp_stall <= 1'b0;
                1: rsp_stall <= ($urandom_range(0, 2) == 0);
                2: rsp_stall <= cycle_count[0];
                default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("unexpected result beat: granted_offset %0d status %0d",
                       granted_offset, status);
                fail_count++;
            end
            else
            begin
                arrived_want = pending_answers.pop_front();
                if (granted_offset !== arrived_want.offset)
                begin
                    $error("granted_offset: expected %0d, got %0d",
                           arrived_want.offset, granted_offset);
                    fail_count++;
                end
                if (status !== arrived_want.status)
                begin
                    $error("status: expected %s, got %0d",
                           arrived_want.status.name(), status);
                    fail_count++;
                end
                beats_checked++;
                status_seen[int'(arrived_want.status)]++;
            end
        end
    end

    // offer one request beat, predict its answer once accepted
    task automatic send_beat(input logic op, input logic [ffba_pkg::TID_W-1:0] tid,
                             input logic [ffba_pkg::SIZE_W-1:0] req,
                             input logic [ffba_pkg::OFF_W-1:0] off);
        int gap;
        gap = 0;
        if (gaps_on && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
        if (burst_left > 0)
            burst_left--;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid     <= 1'b1;
        operation     <= op;
        thread_id     <= tid;
        request_bytes <= req;
        free_offset   <= off;
        do
            @(posedge clk);
        while (req_stall);
        pending_answers.push_back(heap_answer(op, tid, req, off));
        beats_sent++;
    endtask

    task automatic alloc_beat(input logic [ffba_pkg::TID_W-1:0] tid,
                              input logic [ffba_pkg::SIZE_W-1:0] req);
        send_beat(ffba_pkg::OP_ALLOC, tid, req, ffba_pkg::OFF_W'($urandom_range(0, 65535)));
    endtask

    task automatic free_beat(input logic [ffba_pkg::TID_W-1:0] tid,
                             input logic [ffba_pkg::OFF_W-1:0] off);
        send_beat(ffba_pkg::OP_FREE, tid, ffba_pkg::SIZE_W'($urandom_range(0, 131071)), off);
    endtask

    // heap size write, only once the block has drained
    task automatic set_heap(input logic [ffba_pkg::SIZE_W-1:0] bytes);
        req_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= bytes;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        heap_reg = bytes;
        clear_heap_tables();
        heap_writes++;
    endtask

    task automatic random_beat();
        int                         r;
        logic [ffba_pkg::TID_W-1:0] tid;
        tid = ffba_pkg::TID_W'($urandom_range(0, NT - 1));
        r = $urandom_range(0, 99);
        if (r < 55)
            alloc_beat(tid, rand_request());
        else if (r < 90)
            free_beat(tid, pick_listed_offset(tid, r < 84));
        else
            free_beat(tid, ffba_pkg::OFF_W'($urandom_range(0, 65535)));
    endtask

    // reset heap: exact fit, split, double free, zero size, oversize, misses
    task automatic test_reset_heap_corners();
        alloc_beat(2'd0, 17'd65536);
        alloc_beat(2'd0, 17'd8);
        free_beat(2'd0, 16'd0);
        free_beat(2'd0, 16'd0);
        alloc_beat(2'd0, 17'd0);
        alloc_beat(2'd1, 17'd1);
        alloc_beat(2'd1, 17'd131071);
        alloc_beat(2'd2, 17'd65535);
        free_beat(2'd3, 16'd65535);
        free_beat(2'd1, 16'd65528);
    endtask

    // empty heap, clamped heap, rounded heap, smallest heap
    task automatic test_heap_size_edges();
        set_heap(17'd0);
        alloc_beat(2'd0, 17'd1);
        free_beat(2'd0, 16'd0);
        set_heap(17'd131071);
        alloc_beat(2'd3, 17'd65536);
        set_heap(17'd13);
        alloc_beat(2'd0, 17'd9);
        alloc_beat(2'd1, 17'd8);
        alloc_beat(2'd1, 17'd8);
        alloc_beat(2'd1, 17'd8);
        set_heap(17'd8);
        alloc_beat(2'd2, 17'd7);
    endtask

    // mixed traffic over a spread of heap sizes
    task automatic test_random_traffic();
        logic [ffba_pkg::SIZE_W-1:0] heaps[8];
        heaps = '{17'd65536, 17'd1024, 17'd200, 17'd65535,
                  17'd4096, 17'd24, 17'd131071, 17'd512};
        foreach (heaps[p])
        begin
            set_heap(heaps[p]);
            repeat (250) random_beat();
        end
    endtask

    // receiver holds off while the sender keeps pushing back to back
    task automatic test_output_backpressure();
        set_heap(17'd2048);
        gaps_on = 1'b0;
        long_hold_pending = 1'b1;
        repeat (40) random_beat();
        gaps_on = 1'b1;
    endtask

    initial
    begin
        heap_reg = ffba_pkg::SIZE_W'(ffba_pkg::HEAP_LIMIT);
        clear_heap_tables();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_heap_corners();
        test_heap_size_edges();
        test_random_traffic();
        test_output_backpressure();

        // drain and watch for stray beats
        req_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d request beats, %0d answers checked over %0d heap size writes",
                 beats_sent, beats_checked, heap_writes);
        $display("answers: %0d ok, %0d no fit, %0d zero size, %0d not found; %0d long hold-off",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3], long_holds);
        if (fail_count == 0)
            $display("first_fit_block_allocator_core_tb: clean");
        else
            $display("first_fit_block_allocator_core_tb: errors");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ffba_pkg.sv
rtl/ffba_ram.sv
rtl/ffba_table.sv
rtl/ffba_walker.sv
rtl/first_fit_block_allocator_core.sv
tb/first_fit_block_allocator_core_tb.sv
